@@ rtl/core/dlts_pkg.sv @@
// ----------------------------------------------------------------------------
// dlts_pkg: shared types and constants of the delta list task scheduler
// Request codes, status codes, payload structs and controller commands.
// ----------------------------------------------------------------------------
package dlts_pkg;

  localparam int MaxTasksDef = 16;

  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_DISPATCH = 2'd2,
    REQ_REMOVE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NONE     = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  task_id;
    logic [15:0] delay_ticks;
    logic [15:0] period_ticks;
  } in_item_t;

  typedef struct packed {
    logic        ran;
    logic [7:0]  ran_task;
    logic [1:0]  status;
    logic [4:0]  pending;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RD, S_RDW, S_ADDW, S_SHUP, S_INS, S_FIX,
    S_POP, S_REMW, S_REMFIX, S_SHDN, S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the request
    logic rd_pos;    // start the shift-up at the end of the list
    logic step_walk; // add walk: subtract delta, advance pos
    logic shup;      // move entry k-1 to k, k--
    logic ins;       // write new entry at pos
    logic fix;       // adjust successor delta (add or remove)
    logic tick;      // decrement head
    logic pop;       // begin removal of head, prepare reinsert
    logic rem_step;  // remove search: advance pos
    logic shdn;      // move entry k+1 to k, k++
    logic set_done;  // register result
    logic [1:0] st;  // status to report
    logic reins;     // after pop, reinsert
    logic rd_prev;   // issue a read at k-1
    logic rd_next;   // issue a read at k+1
    logic drop;      // entry count down by one
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_t req;
    logic empty;
    logic full;
    logic head_zero;
    logic walk_go;   // pos < count and rem >= delta[pos]
    logic pos_end;   // pos == count
    logic match;     // task[pos] == id
    logic shup_end;  // k == pos
    logic shdn_end;  // k+1 >= count
    logic has_succ;  // pos != count (an entry at pos)
    logic period_nz;
  } stat_t;

endpackage

@@ rtl/core/dlts_datapath.sv @@
// ----------------------------------------------------------------------------
// dlts_datapath: list storage and arithmetic
// Holds the list memory, walk pointer, remainder and entry count.
// ----------------------------------------------------------------------------
module dlts_datapath #(
  parameter int MAX_TASKS = dlts_pkg::MaxTasksDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dlts_pkg::in_item_t in_item,
  input  dlts_pkg::cmd_t     cmd,
  output dlts_pkg::stat_t    stat,
  output dlts_pkg::out_item_t res
);
  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  // List memory; one entry holds id, delta and period.
  logic [39:0] mem [MAX_TASKS];
  logic [39:0] rd_r;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [39:0]   wdata;

  logic [1:0]  req_r;
  logic [7:0]  id_r;
  logic [15:0] per_r;
  logic [15:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, pos_r, pos_nxt, k_r, k_nxt;
  logic [15:0] hd_r, hd_nxt;   // copy of the head delta
  logic [39:0] hold_r, hold_nxt; // popped head entry
  dlts_pkg::out_item_t res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  // Read address selection.
  always_comb begin
    raddr = pos_r[AW-1:0];
    if (cmd.rd_prev) raddr = AW'(k_r - CW'(1));
    else if (cmd.rd_next) raddr = AW'(k_r + CW'(1));
    else if (cmd.shup) raddr = AW'(k_r - CW'(2));
    else if (cmd.shdn) raddr = AW'(k_r + CW'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      hd_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      hd_r  <= hd_nxt;
    end
    rem_r <= rem_nxt; pos_r <= pos_nxt; k_r <= k_nxt; hold_r <= hold_nxt;
    res_r <= res_nxt;
    if (cmd.load) begin
      req_r <= in_item.req_type; id_r <= in_item.task_id; per_r <= in_item.period_ticks;
    end else if (cmd.pop) begin
      id_r <= rd_r[39:32]; per_r <= rd_r[15:0];
    end
  end

  logic [16:0] sum;
  assign sum = {1'b0, rd_r[31:16]} + {1'b0, rem_r};

  // Datapath updates per command.
  always_comb begin
    cnt_nxt = cnt_r; pos_nxt = pos_r; k_nxt = k_r; rem_nxt = rem_r;
    hold_nxt = hold_r; hd_nxt = hd_r; res_nxt = res_r;
    we = 1'b0; waddr = pos_r[AW-1:0]; wdata = rd_r;
    if (cmd.load) begin
      pos_nxt = '0; rem_nxt = in_item.delay_ticks;
    end
    if (cmd.reins) begin
      pos_nxt = '0; rem_nxt = per_r;
    end
    if (cmd.step_walk) begin
      rem_nxt = rem_r - rd_r[31:16]; pos_nxt = pos_r + CW'(1);
    end
    if (cmd.rd_pos) k_nxt = cnt_r;
    if (cmd.shup) begin
      // rd_r holds entry k-1 (read last cycle).
      we = 1'b1; waddr = AW'(k_r); wdata = rd_r; k_nxt = k_r - CW'(1);
    end
    if (cmd.ins) begin
      we = 1'b1; waddr = pos_r[AW-1:0]; wdata = {id_r, rem_r, per_r};
      cnt_nxt = cnt_r + CW'(1);
      if (pos_r == '0) hd_nxt = rem_r;
      pos_nxt = pos_r + CW'(1);
    end
    if (cmd.fix) begin
      // rd_r holds the successor entry at pos.
      we = 1'b1; waddr = pos_r[AW-1:0];
      if (req_r == dlts_pkg::REQ_REMOVE)
        wdata = {rd_r[39:32], sum[16] ? 16'hFFFF : sum[15:0], rd_r[15:0]};
      else
        wdata = {rd_r[39:32], rd_r[31:16] - rem_r, rd_r[15:0]};
      if (pos_r == '0) hd_nxt = wdata[31:16];
    end
    if (cmd.tick) begin
      we = 1'b1; waddr = '0; wdata = {rd_r[39:32], hd_r - 16'd1, rd_r[15:0]};
      hd_nxt = hd_r - 16'd1;
    end
    if (cmd.pop) begin
      k_nxt = '0; rem_nxt = '0;
    end
    if (cmd.rem_step) begin
      pos_nxt = pos_r + CW'(1); rem_nxt = rd_r[31:16]; k_nxt = pos_r;
    end
    if (cmd.shdn) begin
      // rd_r holds entry k+1.
      we = 1'b1; waddr = AW'(k_r); wdata = rd_r; k_nxt = k_r + CW'(1);
      if (k_r == '0) hd_nxt = rd_r[31:16];
    end
    if (cmd.drop) cnt_nxt = cnt_r - CW'(1);
    if (cmd.set_done) begin
      res_nxt.ran      = (req_r == dlts_pkg::REQ_DISPATCH) && (cmd.st == dlts_pkg::ST_OK);
      res_nxt.ran_task = res_nxt.ran ? hold_r[39:32] : 8'd0;
      res_nxt.status   = cmd.st;
      res_nxt.pending  = 5'(cnt_nxt);
    end
    if (cmd.pop) hold_nxt = rd_r;
  end

  always_comb begin
    stat.req       = dlts_pkg::req_t'(req_r);
    stat.empty     = (cnt_r == '0);
    stat.full      = (cnt_r >= CW'(MAX_TASKS));
    stat.head_zero = (hd_r == '0);
    stat.pos_end   = (pos_r == cnt_r);
    stat.walk_go   = (pos_r != cnt_r) && (rem_r >= rd_r[31:16]);
    stat.match     = (rd_r[39:32] == id_r);
    stat.shup_end  = (k_r == pos_r);
    stat.shdn_end  = (k_r + CW'(1) >= cnt_r);
    stat.has_succ  = (pos_r != cnt_r);
    stat.period_nz = (per_r != '0);
  end

  assign res = res_r;
endmodule

@@ rtl/core/dlts_ctrl.sv @@
// ----------------------------------------------------------------------------
// dlts_ctrl: request sequencer
// Steps the datapath through add, tick, dispatch and remove transactions.
// ----------------------------------------------------------------------------
module dlts_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  dlts_pkg::stat_t stat,
  output dlts_pkg::cmd_t  cmd
);
  dlts_pkg::state_t state_r, state_nxt;
  logic ov_r, ov_nxt;
  logic rem_r, rem_nxt; // current pass removes (vs. add)
  logic shd_r, shd_nxt; // removal shift-down started

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dlts_pkg::S_IDLE; ov_r <= 1'b0; rem_r <= 1'b0; shd_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt; rem_r <= rem_nxt; shd_r <= shd_nxt;
    end
  end

  assign out_valid = ov_r;
  assign in_ready  = (state_r == dlts_pkg::S_IDLE) && !ov_r;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r; cmd = '0; rem_nxt = rem_r; shd_nxt = shd_r;
    ov_nxt = ov_r && !out_ready;
    case (state_r)
      dlts_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1; state_nxt = dlts_pkg::S_DECODE;
        end
      end
      dlts_pkg::S_DECODE: begin
        state_nxt = dlts_pkg::S_DONE; cmd.st = dlts_pkg::ST_OK;
        case (stat.req)
          dlts_pkg::REQ_ADD: begin
            if (stat.full) cmd.st = dlts_pkg::ST_FULL;
            else begin
              rem_nxt = 1'b0; state_nxt = dlts_pkg::S_RD;
            end
          end
          dlts_pkg::REQ_TICK: begin
            if (stat.empty) cmd.st = dlts_pkg::ST_NONE;
            else if (!stat.head_zero) state_nxt = dlts_pkg::S_RD;
          end
          dlts_pkg::REQ_DISPATCH: begin
            if (stat.empty || !stat.head_zero) cmd.st = dlts_pkg::ST_NONE;
            else begin
              rem_nxt = 1'b0; shd_nxt = 1'b0; state_nxt = dlts_pkg::S_RD;
            end
          end
          default: begin
            if (stat.empty) cmd.st = dlts_pkg::ST_NONE;
            else begin
              rem_nxt = 1'b1; shd_nxt = 1'b0; state_nxt = dlts_pkg::S_RD;
            end
          end
        endcase
        if (state_nxt == dlts_pkg::S_DONE) cmd.set_done = 1'b1;
      end
      dlts_pkg::S_RD: state_nxt = dlts_pkg::S_RDW;
      dlts_pkg::S_RDW: begin
        // rd_r now holds the entry at pos.
        if (stat.req == dlts_pkg::REQ_TICK) begin
          cmd.tick = 1'b1; cmd.set_done = 1'b1; state_nxt = dlts_pkg::S_DONE;
        end else if (stat.req == dlts_pkg::REQ_DISPATCH && !rem_r && !shd_r) begin
          cmd.pop = 1'b1; shd_nxt = 1'b1; state_nxt = dlts_pkg::S_SHDN;
        end else if (!rem_r) begin
          if (stat.walk_go) begin
            cmd.step_walk = 1'b1; state_nxt = dlts_pkg::S_RD;
          end else begin
            cmd.rd_pos = 1'b1; state_nxt = dlts_pkg::S_SHUP;
          end
        end else if (stat.pos_end) begin
          cmd.st = dlts_pkg::ST_NOTFOUND; cmd.set_done = 1'b1;
          state_nxt = dlts_pkg::S_DONE;
        end else if (stat.match) begin
          cmd.rem_step = 1'b1; state_nxt = dlts_pkg::S_REMW;
        end else begin
          cmd.rem_step = 1'b1; state_nxt = dlts_pkg::S_RD;
        end
      end
      dlts_pkg::S_SHUP: begin
        // Shift entries up to open a gap at pos; each move needs a read first.
        cmd.rd_prev = 1'b1;
        if (stat.shup_end) state_nxt = dlts_pkg::S_INS;
        else state_nxt = dlts_pkg::S_ADDW;
      end
      dlts_pkg::S_ADDW: begin
        cmd.shup = 1'b1; state_nxt = dlts_pkg::S_SHUP;
      end
      dlts_pkg::S_INS: begin
        cmd.ins = 1'b1; state_nxt = dlts_pkg::S_FIX;
      end
      dlts_pkg::S_FIX: begin
        if (stat.has_succ) state_nxt = dlts_pkg::S_POP;
        else begin
          cmd.set_done = 1'b1; state_nxt = dlts_pkg::S_DONE;
        end
      end
      dlts_pkg::S_POP: begin
        // Read of the successor has landed.
        cmd.fix = 1'b1;
        if (rem_r) state_nxt = dlts_pkg::S_SHDN;
        else begin
          cmd.set_done = 1'b1; state_nxt = dlts_pkg::S_DONE;
        end
      end
      dlts_pkg::S_REMW: begin
        // Matched entry at k; pos is its successor, rem holds its delta.
        if (stat.has_succ) state_nxt = dlts_pkg::S_FIX;
        else state_nxt = dlts_pkg::S_SHDN;
      end
      dlts_pkg::S_SHDN: begin
        // Fetch the entry that moves down next.
        cmd.rd_next = 1'b1;
        state_nxt = dlts_pkg::S_REMFIX;
      end
      dlts_pkg::S_REMFIX: begin
        if (stat.shdn_end) begin
          cmd.shdn = 1'b0;
          cmd.drop = 1'b1;
          state_nxt = dlts_pkg::S_DONE;
          cmd.set_done = 1'b1;
        end else begin
          cmd.shdn = 1'b1; state_nxt = dlts_pkg::S_SHDN;
        end
        if (stat.shdn_end && stat.req == dlts_pkg::REQ_DISPATCH) begin
          cmd.set_done = 1'b0;
          if (stat.period_nz) begin
            cmd.reins = 1'b1; rem_nxt = 1'b0; state_nxt = dlts_pkg::S_RD;
          end else begin
            cmd.set_done = 1'b1;
          end
        end
      end
      dlts_pkg::S_DONE: begin
        ov_nxt = 1'b1; state_nxt = dlts_pkg::S_IDLE;
      end
      default: state_nxt = dlts_pkg::S_IDLE;
    endcase
  end
endmodule

@@ rtl/core/delta_list_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// delta_list_task_scheduler: sorted delta list of timed tasks
// Requests settled at decode finish first, then a tick that lowers the head;
// add, remove and dispatch take longest, as they walk and shift over the
// list one entry at a time.
// One transaction is worked at a time; the next is taken the cycle after the
// result leaves the output register.
// Synchronous reset empties the list; entry storage is not cleared.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler #(
  parameter int MAX_TASKS = dlts_pkg::MaxTasksDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dlts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dlts_pkg::out_item_t out_data
);
  dlts_pkg::cmd_t  cmd;
  dlts_pkg::stat_t stat;

  dlts_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  dlts_datapath #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk, .rst_n, .in_item(in_data), .cmd, .stat, .res(out_data)
  );

  // A result never claims more entries than the list holds.
  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.pending) <= MAX_TASKS)) else $error("pending too large");
  // A result that ran a task reports status ok.
  a_ran: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ran |-> out_data.status == dlts_pkg::ST_OK)
    else $error("ran with bad status");
  // No new transaction while a result waits.
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready during pending result");
endmodule
